>>> hdl/pbw_pkg.sv
// ----------------------------------------------------------------------------
// pbw_pkg
// Types and constants shared by the top-level protobuf field walker.
// ----------------------------------------------------------------------------
`default_nettype none

package pbw_pkg;

    localparam int unsigned VALUE_W = 64;

    // walker phase
    typedef enum logic [5:0] {
        PH_TAG    = 6'b000001,
        PH_VALUE  = 6'b000010,
        PH_LENGTH = 6'b000100,
        PH_SKIP   = 6'b001000,
        PH_PASS   = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // wire types
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // tracked field codes
    localparam logic [2:0] CF_UNKNOWN = 3'd0;
    localparam logic [2:0] CF_VERSION = 3'd1;
    localparam logic [2:0] CF_NAME    = 3'd2;
    localparam logic [2:0] CF_VSTR    = 3'd3;
    localparam logic [2:0] CF_GRAPH   = 3'd7;

    // result kinds
    localparam logic [2:0] KIND_VERSION   = 3'd0;
    localparam logic [2:0] KIND_NAME_BYTE = 3'd1;
    localparam logic [2:0] KIND_VSTR_BYTE = 3'd2;
    localparam logic [2:0] KIND_GRAPH_LEN = 3'd3;
    localparam logic [2:0] KIND_GRAPH_BYTE = 3'd4;
    localparam logic [2:0] KIND_END       = 3'd5;

    localparam logic [3:0]         VARINT_MAX_BYTES = 4'd10;
    localparam logic [VALUE_W-1:0] LEN_FIXED64      = 64'd8;
    localparam logic [VALUE_W-1:0] LEN_FIXED32      = 64'd4;

    typedef struct packed {
        logic               valid;
        logic [2:0]         kind;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               trunc;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/pbw_walker.sv
// ----------------------------------------------------------------------------
// pbw_walker
// Walker state and per-byte decode: tag, varint, skip and pass phases.
// ----------------------------------------------------------------------------
`default_nettype none

module pbw_walker
    import pbw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic       mode,
    input  wire logic [7:0] data_byte,
    output result_t         res
);

    phase_t               phase_reg, phase_next;
    logic [2:0]           field_reg, field_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic [3:0]           shift_reg, shift_next;
    logic [VALUE_W-1:0]   rem_reg, rem_next;
    logic                 done_reg, done_next;

    logic [VALUE_W-1:0]   acc_taken;
    logic [3:0]           shift_taken;
    logic [6:0]           shift_amt;
    logic                 varint_end;
    logic [VALUE_W-1:0]   rem_dec;
    logic [4:0]           tag_field;
    logic [2:0]           tag_wt;
    logic [2:0]           pass_kind;

    always_comb begin
        shift_amt   = ({3'b000, shift_reg} << 3) - {3'b000, shift_reg};
        varint_end  = ~data_byte[7];
        if (shift_reg < VARINT_MAX_BYTES) begin
            acc_taken   = acc_reg | ({{(VALUE_W-7){1'b0}}, data_byte[6:0]} << shift_amt);
            shift_taken = shift_reg + 4'd1;
        end else begin
            acc_taken   = acc_reg;
            shift_taken = shift_reg;
        end
        rem_dec   = rem_reg - {{(VALUE_W-1){1'b0}}, 1'b1};
        tag_field = data_byte[7:3];
        tag_wt    = data_byte[2:0];
        case (field_reg)
            CF_NAME: pass_kind = KIND_NAME_BYTE;
            CF_VSTR: pass_kind = KIND_VSTR_BYTE;
            default: pass_kind = KIND_GRAPH_BYTE;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        field_next = field_reg;
        acc_next   = acc_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        done_next  = done_reg;
        res        = '0;

        if (mode) begin
            res.valid  = 1'b1;
            res.kind   = KIND_END;
            res.trunc  = ~done_reg && (phase_reg != PH_TAG) && (phase_reg != PH_DONE);
            phase_next = PH_TAG;
            field_next = CF_UNKNOWN;
            acc_next   = '0;
            shift_next = '0;
            rem_next   = '0;
            done_next  = 1'b0;
        end else begin
            unique case (phase_reg)
                PH_TAG: begin
                    if (tag_field == {2'b00, CF_VERSION}) begin
                        if (tag_wt == WT_VARINT) begin
                            phase_next = PH_VALUE;
                            field_next = CF_VERSION;
                            acc_next   = '0;
                            shift_next = '0;
                        end
                    end else if (tag_field == {2'b00, CF_NAME}
                                 || tag_field == {2'b00, CF_VSTR}
                                 || tag_field == {2'b00, CF_GRAPH}) begin
                        if (tag_wt == WT_LEN) begin
                            phase_next = PH_LENGTH;
                            field_next = tag_field[2:0];
                            acc_next   = '0;
                            shift_next = '0;
                        end
                    end else begin
                        case (tag_wt)
                            WT_VARINT: begin
                                phase_next = PH_VALUE;
                                field_next = CF_UNKNOWN;
                                acc_next   = '0;
                                shift_next = '0;
                            end
                            WT_FIXED64: begin
                                phase_next = PH_SKIP;
                                field_next = CF_UNKNOWN;
                                rem_next   = LEN_FIXED64;
                            end
                            WT_LEN: begin
                                phase_next = PH_LENGTH;
                                field_next = CF_UNKNOWN;
                                acc_next   = '0;
                                shift_next = '0;
                            end
                            WT_FIXED32: begin
                                phase_next = PH_SKIP;
                                field_next = CF_UNKNOWN;
                                rem_next   = LEN_FIXED32;
                            end
                            default: ;
                        endcase
                    end
                end
                PH_VALUE: begin
                    acc_next   = acc_taken;
                    shift_next = shift_taken;
                    if (varint_end) begin
                        phase_next = PH_TAG;
                        if (field_reg == CF_VERSION) begin
                            res.valid = 1'b1;
                            res.kind  = KIND_VERSION;
                            res.value = acc_taken;
                        end
                    end
                end
                PH_LENGTH: begin
                    acc_next   = acc_taken;
                    shift_next = shift_taken;
                    if (varint_end) begin
                        rem_next = acc_taken;
                        if (field_reg == CF_GRAPH) begin
                            res.valid = 1'b1;
                            res.kind  = KIND_GRAPH_LEN;
                            res.value = acc_taken;
                            if (acc_taken == '0) begin
                                phase_next = PH_DONE;
                                done_next  = 1'b1;
                            end else begin
                                phase_next = PH_PASS;
                            end
                        end else if (acc_taken == '0) begin
                            phase_next = PH_TAG;
                        end else if (field_reg == CF_UNKNOWN) begin
                            phase_next = PH_SKIP;
                        end else begin
                            phase_next = PH_PASS;
                        end
                    end
                end
                PH_SKIP: begin
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        phase_next = PH_TAG;
                    end
                end
                PH_PASS: begin
                    rem_next  = rem_dec;
                    res.valid = 1'b1;
                    res.kind  = pass_kind;
                    res.value = {{(VALUE_W-8){1'b0}}, data_byte};
                    res.last  = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        if (field_reg == CF_GRAPH) begin
                            phase_next = PH_DONE;
                            done_next  = 1'b1;
                        end else begin
                            phase_next = PH_TAG;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TAG;
            field_reg <= CF_UNKNOWN;
            acc_reg   <= '0;
            shift_reg <= '0;
            rem_reg   <= '0;
            done_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            field_reg <= field_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/protobuf_top_level_field_walker_unit.sv
// output: the result of an accepted request appears in the output register in the next cycle
// throughput: one byte request per cycle while s_ready is high, set by the single walker state register stage
// a new request is taken while the output register is empty or being drained in that cycle
// reset: synchronous active-low aresetn returns the walker to tag search and empties the output
// ----------------------------------------------------------------------------
// protobuf_top_level_field_walker_unit
// Byte-serial protobuf top-level field walker with a registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module protobuf_top_level_field_walker_unit
    import pbw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_mode,
    input  wire logic [7:0]         s_data_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_kind,
    output logic [VALUE_W-1:0]      m_value,
    output logic                    m_last_of_field,
    output logic                    m_truncated
);

    result_t step_res;
    result_t out_reg;
    logic    m_valid_reg;
    logic    s_accept;

    assign s_ready  = ~m_valid_reg | m_ready;
    assign s_accept = s_valid & s_ready;

    pbw_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (s_accept),
        .mode      (s_mode),
        .data_byte (s_data_byte),
        .res       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= step_res.valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_reg <= step_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_value         = out_reg.value;
    assign m_last_of_field = out_reg.last;
    assign m_truncated     = out_reg.trunc;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_mode) |=> (m_valid && m_kind == KIND_END))
        else $error("end request gave no end result");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_field) |-> (m_kind == KIND_NAME_BYTE
            || m_kind == KIND_VSTR_BYTE || m_kind == KIND_GRAPH_BYTE))
        else $error("last flag on a non-byte result");

    a_trunc_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_truncated) |-> (m_kind == KIND_END))
        else $error("truncated flag on a non-end result");

endmodule

`default_nettype wire
